>>> src/utf8d_pkg.sv
`default_nettype none
package utf8d_pkg;

   localparam int unsigned ByteW = 8;
   localparam int unsigned CpW = 21;
   localparam int unsigned LenW = 3;
   localparam int unsigned SeenW = 2;
   localparam int unsigned RepW = 2;

   localparam logic [CpW-1:0] Replacement = 21'h00FFFD;
   localparam logic [1:0] ContTag = 2'b10;

   typedef struct packed {
      logic [LenW-1:0] seq_length;
      logic [SeenW-1:0] bytes_seen;
      logic [CpW-1:0] partial_code;
   } dec_state_type;

   typedef struct packed {
      logic [RepW-1:0] rep_cnt;
      logic tail_valid;
      logic tail_rep;
      logic [CpW-1:0] tail_cp;
   } burst_type;

endpackage
`default_nettype wire

>>> src/utf8d_decode.sv
`default_nettype none
module utf8d_decode (
   input wire logic [utf8d_pkg::ByteW-1:0] in_byte,
   input wire utf8d_pkg::dec_state_type state,
   output utf8d_pkg::dec_state_type state_next,
   output utf8d_pkg::burst_type burst
);
   import utf8d_pkg::*;

   logic [LenW-1:0] ones;
   logic [SeenW-1:0] seen_inc;
   logic [CpW-1:0] partial_shift;
   logic [LenW-1:0] seen_done;
   dec_state_type lead_state;
   burst_type lead_burst;

   always_comb begin
      if (in_byte[7:3] == 5'b11111) begin
         ones = 3'd5;
      end else if (in_byte[7:4] == 4'b1111) begin
         ones = 3'd4;
      end else if (in_byte[7:5] == 3'b111) begin
         ones = 3'd3;
      end else if (in_byte[7:6] == 2'b11) begin
         ones = 3'd2;
      end else if (in_byte[7]) begin
         ones = 3'd1;
      end else begin
         ones = 3'd0;
      end
   end

   always_comb begin
      lead_state = '0;
      lead_burst = '0;
      case (ones)
         3'd0: begin
            lead_burst.tail_valid = 1'b1;
            lead_burst.tail_cp = {{(CpW-ByteW){1'b0}}, in_byte};
         end
         3'd2: begin
            lead_state.seq_length = ones;
            lead_state.partial_code = {{(CpW-5){1'b0}}, in_byte[4:0]};
         end
         3'd3: begin
            lead_state.seq_length = ones;
            lead_state.partial_code = {{(CpW-4){1'b0}}, in_byte[3:0]};
         end
         3'd4: begin
            lead_state.seq_length = ones;
            lead_state.partial_code = {{(CpW-3){1'b0}}, in_byte[2:0]};
         end
         default: begin
            lead_burst.tail_valid = 1'b1;
            lead_burst.tail_rep = 1'b1;
            lead_burst.tail_cp = Replacement;
         end
      endcase
   end

   assign seen_inc = state.bytes_seen + 2'd1;
   assign seen_done = {1'b0, seen_inc} + 3'd1;
   assign partial_shift = {state.partial_code[CpW-7:0], in_byte[5:0]};

   always_comb begin
      state_next = state;
      burst = '0;
      if (state.seq_length == '0) begin
         state_next = lead_state;
         burst = lead_burst;
      end else if (in_byte[7:6] == ContTag) begin
         if (seen_done >= state.seq_length) begin
            state_next = '0;
            burst.tail_valid = 1'b1;
            burst.tail_cp = partial_shift;
         end else begin
            state_next.bytes_seen = seen_inc;
            state_next.partial_code = partial_shift;
         end
      end else begin
         state_next = lead_state;
         burst = lead_burst;
         burst.rep_cnt = (state.bytes_seen >= 2'd2) ? 2'd3 : state.bytes_seen + 2'd1;
      end
   end

endmodule
`default_nettype wire

>>> src/utf8_stream_decoder_core.sv
`default_nettype none
// A word is registered, decoded combinationally, and its first result is
// registered in the result stage. One word per cycle while that stage is
// free; a word that yields k results holds the result register until all k
// (at most four) are taken, and the input register stalls behind it. A word
// yielding no result waits only while the results of an earlier word drain.
// Reset: synchronous, active high; clears the decoder to idle and both stages
// to empty.
module utf8_stream_decoder_core (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [utf8d_pkg::ByteW-1:0] req_in_byte,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [utf8d_pkg::CpW-1:0] rsp_code_point,
   output logic rsp_replaced,
   output logic rsp_last_of_run
);
   import utf8d_pkg::*;

   logic in_valid_ff;
   logic in_valid_in;
   logic [ByteW-1:0] in_byte_ff;
   dec_state_type state_ff;
   dec_state_type state_in;
   burst_type dec_burst;
   burst_type out_ff;
   burst_type out_in;
   logic out_busy;
   logic out_last;
   logic out_free;
   logic consume;
   logic accept;

   utf8d_decode u_decode (
      .in_byte(in_byte_ff),
      .state(state_ff),
      .state_next(state_in),
      .burst(dec_burst)
   );

   assign out_busy = (out_ff.rep_cnt != '0) || out_ff.tail_valid;
   assign out_last = (out_ff.rep_cnt == '0) ||
                     ((out_ff.rep_cnt == 2'd1) && !out_ff.tail_valid);
   assign out_free = !out_busy || (out_last && !rsp_stall);
   assign consume = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !consume);

   assign rsp_valid = out_busy;
   assign rsp_code_point = (out_ff.rep_cnt != '0) ? Replacement : out_ff.tail_cp;
   assign rsp_replaced = (out_ff.rep_cnt != '0) ? 1'b1 : out_ff.tail_rep;
   assign rsp_last_of_run = out_last;

   always_comb begin
      out_in = out_ff;
      if (consume) begin
         out_in = dec_burst;
      end else if (out_busy && !rsp_stall) begin
         if (out_ff.rep_cnt != '0) begin
            out_in.rep_cnt = out_ff.rep_cnt - 2'd1;
         end else begin
            out_in.tail_valid = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
      end
      out_ff.tail_rep <= out_in.tail_rep;
      out_ff.tail_cp <= out_in.tail_cp;
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff <= '0;
         out_ff.rep_cnt <= '0;
         out_ff.tail_valid <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (consume) begin
            state_ff <= state_in;
         end
         out_ff.rep_cnt <= out_in.rep_cnt;
         out_ff.tail_valid <= out_in.tail_valid;
      end
   end

endmodule
`default_nettype wire
